// ===== src/otb_pkg.sv =====
// Shared types and codes for the one-shot timer bank.
`default_nettype none

package otb_pkg;

    // Request codes carried on the input channel.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_TICK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
        logic sweep_rd;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_tick;
        logic out_free;
    } ctrl_sts_t;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned DUR_W    = 32;
    localparam int unsigned FLAGS_W  = 16;

endpackage

`default_nettype wire

// ===== src/otb_ctrl.sv =====
// Controller state machine that sequences requests and the tick sweep.
`default_nettype none

module otb_ctrl #(
    parameter int unsigned NUM_TIMERS = 16,
    parameter int unsigned IDX_W      = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  otb_pkg::ctrl_sts_t     sts,
    output otb_pkg::ctrl_cmd_t     cmd,
    output logic [IDX_W-1:0]       sweep_addr
);
    import otb_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             cnt_last;

    assign cnt_last   = (cnt_reg == IDX_W'(NUM_TIMERS - 1));
    assign sweep_addr = cnt_reg;

    // State and sweep counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = sts.in_is_tick ? ST_TICK : ST_APPLY;
                end
            end
            ST_APPLY: begin
                state_next = ST_DONE;
            end
            ST_TICK: begin
                if (cnt_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
            end
            ST_TICK: begin
                cmd.sweep_rd = 1'b1;
            end
            ST_DRAIN: begin
                cmd = '0;
            end
            ST_DONE: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/otb_datapath.sv =====
// Timer state, duration and elapsed memories, tick update and result register.
`default_nettype none

module otb_datapath #(
    parameter int unsigned NUM_TIMERS = 16,
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned IDX_W      = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  otb_pkg::ctrl_cmd_t                 cmd,
    output otb_pkg::ctrl_sts_t                 sts,
    input  wire logic [IDX_W-1:0]              sweep_addr,
    input  wire logic [otb_pkg::REQ_W-1:0]     s_req_type,
    input  wire logic [otb_pkg::INDEX_W-1:0]   s_timer_index,
    input  wire logic [otb_pkg::DUR_W-1:0]     s_duration_ms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [otb_pkg::FLAGS_W-1:0]        m_timeout_flags,
    output logic [otb_pkg::FLAGS_W-1:0]        m_running_flags,
    output logic                               m_selected_timeout
);
    import otb_pkg::*;

    localparam int unsigned XW = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    // Captured request.
    req_t                 req_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [COUNT_BITS-1:0] dur_reg;

    // Per-timer flags.
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] expired_reg, expired_next;

    // Memories and their registered read data.
    logic [COUNT_BITS-1:0] duration_mem [NUM_TIMERS];
    logic [COUNT_BITS-1:0] elapsed_mem  [NUM_TIMERS];
    logic [COUNT_BITS-1:0] dur_rd_reg;
    logic [COUNT_BITS-1:0] el_rd_reg;

    // Update stage of the tick sweep.
    logic                  upd_vld_reg;
    logic [IDX_W-1:0]      upd_idx_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [FLAGS_W-1:0]    tflags_reg;
    logic [FLAGS_W-1:0]    rflags_reg;
    logic                  sel_reg;

    logic [XW-1:0]         idx_ext;
    logic [IDX_W-1:0]      idx_addr;
    logic                  idx_ok;
    logic                  do_start;
    logic                  do_stop;
    logic                  upd_hit;
    logic                  el_we;
    logic [IDX_W-1:0]      el_waddr;
    logic [COUNT_BITS-1:0] el_wdata;
    logic [FLAGS_W-1:0]    tmap;
    logic [FLAGS_W-1:0]    rmap;

    assign idx_ext  = XW'(idx_reg);
    assign idx_addr = idx_ext[IDX_W-1:0];
    assign idx_ok   = ({4'b0, idx_reg} < 8'(NUM_TIMERS));
    assign do_start = cmd.apply && (req_reg == REQ_START) && idx_ok;
    assign do_stop  = cmd.apply && (req_reg == REQ_STOP) && idx_ok;

    assign sts.in_is_tick = (req_t'(s_req_type) == REQ_TICK);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Capture the accepted request.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_t'(s_req_type);
            idx_reg <= s_timer_index;
            dur_reg <= s_duration_ms[COUNT_BITS-1:0];
        end
    end

    // A swept timer whose count reached its duration expires; otherwise it counts.
    assign upd_hit = upd_vld_reg && running_reg[upd_idx_reg] && (dur_rd_reg > el_rd_reg);

    // Elapsed memory write port: start clears, the sweep increments.
    always_comb begin
        el_we    = 1'b0;
        el_waddr = idx_addr;
        el_wdata = '0;
        if (do_start) begin
            el_we = 1'b1;
        end else if (upd_hit) begin
            el_we    = 1'b1;
            el_waddr = upd_idx_reg;
            el_wdata = el_rd_reg + 1'b1;
        end
    end

    // Memories with registered read at the sweep address.
    always_ff @(posedge aclk) begin
        if (do_start) begin
            duration_mem[idx_addr] <= dur_reg;
        end
        if (el_we) begin
            elapsed_mem[el_waddr] <= el_wdata;
        end
        dur_rd_reg <= duration_mem[sweep_addr];
        el_rd_reg  <= elapsed_mem[sweep_addr];
    end

    // Flag updates from start, stop and the sweep.
    always_comb begin
        running_next = running_reg;
        expired_next = expired_reg;
        if (do_start) begin
            running_next[idx_addr] = 1'b1;
            expired_next[idx_addr] = 1'b0;
        end else if (do_stop) begin
            running_next[idx_addr] = 1'b0;
            expired_next[idx_addr] = 1'b0;
        end else if (upd_vld_reg) begin
            if (!running_reg[upd_idx_reg]) begin
                expired_next[upd_idx_reg] = 1'b0;
            end else if (!upd_hit) begin
                expired_next[upd_idx_reg] = 1'b1;
            end
        end
    end

    // Flag and sweep pipeline registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
            expired_reg <= '0;
            upd_vld_reg <= 1'b0;
        end else begin
            running_reg <= running_next;
            expired_reg <= expired_next;
            upd_vld_reg <= cmd.sweep_rd;
        end
    end

    always_ff @(posedge aclk) begin
        upd_idx_reg <= sweep_addr;
    end

    // Bitmaps of the first sixteen timers.
    for (genvar b = 0; b < FLAGS_W; b++) begin : g_map
        if (b < NUM_TIMERS) begin : g_on
            assign tmap[b] = expired_reg[b];
            assign rmap[b] = running_reg[b];
        end else begin : g_off
            assign tmap[b] = 1'b0;
            assign rmap[b] = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            tflags_reg <= tmap;
            rflags_reg <= rmap;
            sel_reg    <= idx_ok && expired_reg[idx_addr];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_timeout_flags    = tflags_reg;
    assign m_running_flags    = rflags_reg;
    assign m_selected_timeout = sel_reg;

endmodule

`default_nettype wire

// ===== src/one_shot_timer_bank_core.sv =====
// Top level of the one-shot timer bank: controller plus datapath.
// A start or stop request passes through the apply and done states before its result
// is loaded into the output register; a tick request passes through the sweep, which
// reads and updates one timer entry per cycle through the elapsed memory port, then drain and done.
// A new request is taken only once the last result is loaded, so the block holds off requests
// while a result waits for m_ready. Reset: aresetn (synchronous, active low) clears all flags.
`default_nettype none

module one_shot_timer_bank_core #(
    parameter int unsigned NUM_TIMERS = 16,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [otb_pkg::REQ_W-1:0]     s_req_type,
    input  wire logic [otb_pkg::INDEX_W-1:0]   s_timer_index,
    input  wire logic [otb_pkg::DUR_W-1:0]     s_duration_ms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [otb_pkg::FLAGS_W-1:0]        m_timeout_flags,
    output logic [otb_pkg::FLAGS_W-1:0]        m_running_flags,
    output logic                               m_selected_timeout
);
    import otb_pkg::*;

    localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    ctrl_cmd_t        cmd;
    ctrl_sts_t        sts;
    logic [IDX_W-1:0] sweep_addr;

    otb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd),
        .sweep_addr (sweep_addr)
    );

    otb_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .sweep_addr         (sweep_addr),
        .s_req_type         (s_req_type),
        .s_timer_index      (s_timer_index),
        .s_duration_ms      (s_duration_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_timeout_flags    (m_timeout_flags),
        .m_running_flags    (m_running_flags),
        .m_selected_timeout (m_selected_timeout)
    );

endmodule

`default_nettype wire

// ===== src/otb_checker.sv =====
// Port-level assertions for the timer bank and the bind that attaches them.
`default_nettype none

module otb_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [otb_pkg::FLAGS_W-1:0]   m_timeout_flags,
    input wire logic [otb_pkg::FLAGS_W-1:0]   m_running_flags
);
    import otb_pkg::*;

    // A pending result is held until taken.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // No result is shown right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One request at a time: no second request is taken the cycle after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // A timer can only have expired while it is running.
    a_expired_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_timeout_flags & ~m_running_flags) == '0))
        else $error("timeout flag set on a stopped timer");

endmodule

bind one_shot_timer_bank_core otb_checker u_otb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_timeout_flags (m_timeout_flags),
    .m_running_flags (m_running_flags)
);

`default_nettype wire

// ===== verif/tb_one_shot_timer_bank_core.sv =====
// Self-checking testbench for the one-shot timer bank core.
`timescale 1ns / 100ps

module tb_one_shot_timer_bank_core;
    import otb_pkg::*;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned N_TIMERS    = 16;
    localparam int unsigned CNT_W       = 32;
    // A tick sweeps every entry; leave room beyond that before ending.
    localparam int unsigned SETTLE_CYCLES = N_TIMERS + 16;

    // One result as seen on the output channel.
    typedef struct packed {
        logic [FLAGS_W-1:0] timeout_flags;
        logic [FLAGS_W-1:0] running_flags;
        logic               selected_timeout;
    } timer_status_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type;
    logic [INDEX_W-1:0]   s_timer_index;
    logic [DUR_W-1:0]     s_duration_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic [FLAGS_W-1:0]   m_timeout_flags;
    logic [FLAGS_W-1:0]   m_running_flags;
    logic                 m_selected_timeout;

    // Shadow copy of the timer bank.
    logic                 timer_running [N_TIMERS];
    logic                 timer_expired [N_TIMERS];
    logic [CNT_W-1:0]     timer_duration [N_TIMERS];
    logic [CNT_W-1:0]     timer_elapsed [N_TIMERS];

    timer_status_t        awaited_status [$];
    int                   error_count = 0;
    bit                   idle_enabled = 1'b1;

    one_shot_timer_bank_core #(
        .NUM_TIMERS (N_TIMERS),
        .COUNT_BITS (CNT_W)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_timer_index      (s_timer_index),
        .s_duration_ms      (s_duration_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_timeout_flags    (m_timeout_flags),
        .m_running_flags    (m_running_flags),
        .m_selected_timeout (m_selected_timeout)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one request to the shadow bank and return the status it should produce.
    function automatic timer_status_t next_timer_status(req_t req, logic [INDEX_W-1:0] idx,
                                                        logic [DUR_W-1:0] dur);
        timer_status_t st;
        st = '0;
        case (req)
            REQ_TICK: begin
                for (int t = 0; t < N_TIMERS; t++) begin
                    if (timer_running[t]) begin
                        if (timer_duration[t] <= timer_elapsed[t]) begin
                            timer_expired[t] = 1'b1;
                        end else begin
                            timer_elapsed[t] = timer_elapsed[t] + 1'b1;
                        end
                    end else begin
                        timer_expired[t] = 1'b0;
                        timer_elapsed[t] = '0;
                    end
                end
            end
            REQ_START: begin
                timer_running[idx]  = 1'b1;
                timer_expired[idx]  = 1'b0;
                timer_elapsed[idx]  = '0;
                timer_duration[idx] = dur[CNT_W-1:0];
            end
            REQ_STOP: begin
                timer_running[idx] = 1'b0;
                timer_expired[idx] = 1'b0;
                timer_elapsed[idx] = '0;
            end
            default: begin
                // An unused request code leaves the bank untouched.
            end
        endcase
        for (int t = 0; t < N_TIMERS && t < FLAGS_W; t++) begin
            st.timeout_flags[t] = timer_expired[t];
            st.running_flags[t] = timer_running[t];
        end
        st.selected_timeout = timer_expired[idx];
        return st;
    endfunction

    // Send one request, optionally after an idle burst, and record its expected status.
    task automatic send_request(req_t req, logic [INDEX_W-1:0] idx, logic [DUR_W-1:0] dur);
        if (idle_enabled && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_req_type    = req;
        s_timer_index = idx;
        s_duration_ms = dur;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        awaited_status.push_back(next_timer_status(req, idx, dur));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_for_drain();
        while (awaited_status.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return '1;
            default: return $urandom_range(0, 24);
        endcase
    endfunction

    // The unused request code gives a status but changes nothing.
    task automatic test_request_none();
        send_request(REQ_NONE, 4'd3, $urandom());
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_NONE, 4'd15, '1);
    endtask

    // A zero duration expires on the first tick and then holds.
    task automatic test_zero_duration();
        send_request(REQ_START, 4'd0, '0);
        send_request(REQ_TICK, 4'd0, '1);
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_START, 4'd10, '0);
        send_request(REQ_STOP, 4'd10, '0);
        send_request(REQ_TICK, 4'd10, '0);
    endtask

    // A short countdown beside a timer with the longest duration.
    task automatic test_countdown();
        send_request(REQ_START, 4'd15, '1);
        send_request(REQ_START, 4'd7, 32'd2);
        repeat (3) send_request(REQ_TICK, 4'd7, '0);
        send_request(REQ_NONE, 4'd7, '0);
    endtask

    // Stopping clears everything, even on an idle timer, while timer 0 counts to its timeout.
    task automatic test_stop_and_restart();
        send_request(REQ_START, 4'd0, 32'd1);
        send_request(REQ_STOP, 4'd15, '0);
        send_request(REQ_STOP, 4'd7, '1);
        send_request(REQ_STOP, 4'd3, '0);
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_TICK, 4'd0, '0);
    endtask

    // Mixed traffic, weighted toward starts with short durations and ticks.
    task automatic test_random_traffic(int count, bit with_drain);
        int sel;
        req_t req;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 48) begin
                req = REQ_TICK;
            end else if (sel < 78) begin
                req = REQ_START;
            end else if (sel < 94) begin
                req = REQ_STOP;
            end else begin
                req = REQ_NONE;
            end
            if (req == REQ_START) begin
                send_request(req, INDEX_W'($urandom_range(0, 15)), random_duration());
            end else begin
                send_request(req, INDEX_W'($urandom_range(0, 15)), $urandom());
            end
            if (with_drain && n % 97 == 96) wait_for_drain();
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        timer_status_t exp_st;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_status.size() == 0) begin
                $error("unexpected result: timeout_flags %h running_flags %h",
                       m_timeout_flags, m_running_flags);
                error_count++;
            end else begin
                exp_st = awaited_status.pop_front();
                if (m_timeout_flags !== exp_st.timeout_flags) begin
                    $error("timeout_flags: expected %h, got %h",
                           exp_st.timeout_flags, m_timeout_flags);
                    error_count++;
                end
                if (m_running_flags !== exp_st.running_flags) begin
                    $error("running_flags: expected %h, got %h",
                           exp_st.running_flags, m_running_flags);
                    error_count++;
                end
                if (m_selected_timeout !== exp_st.selected_timeout) begin
                    $error("selected_timeout: expected %b, got %b",
                           exp_st.selected_timeout, m_selected_timeout);
                    error_count++;
                end
            end
        end
    end

    // Result-side back-pressure in random bursts.
    initial begin : drive_result_ready
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0 && idle_enabled) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
                m_ready    = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Main sequence: reset, directed tests, random traffic, then a tail with no idling.
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = REQ_TICK;
        s_timer_index = '0;
        s_duration_ms = '0;
        for (int t = 0; t < N_TIMERS; t++) begin
            timer_running[t]  = 1'b0;
            timer_expired[t]  = 1'b0;
            timer_duration[t] = '0;
            timer_elapsed[t]  = '0;
        end
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_request_none();
        test_zero_duration();
        test_countdown();
        test_stop_and_restart();
        wait_for_drain();
        test_random_traffic(850, 1'b1);
        idle_enabled = 1'b0;
        test_random_traffic(150, 1'b0);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && awaited_status.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(6_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== one_shot_timer_bank_core.f =====
src/otb_pkg.sv
src/otb_ctrl.sv
src/otb_datapath.sv
src/one_shot_timer_bank_core.sv
src/otb_checker.sv
verif/tb_one_shot_timer_bank_core.sv
